// ===== sv/atpr_pkg.sv =====
// Package for the accelerometer tilt block: fixed-point constants and the
// arctangent table of the CORDIC stages. No dependencies.
package atpr_pkg;

  localparam int GUARD_BITS = 24;
  localparam int ANGLE_W    = 34;
  localparam int CENTI_W    = 29;
  localparam int DEG_W      = 18;

  localparam logic [30:0]        GAIN_Q30    = 31'd1768195363;
  localparam logic [ANGLE_W-1:0] HALF_PI_Q30 = ANGLE_W'(64'd1686629713);
  localparam logic [CENTI_W-1:0] CENTI_Q16   = 29'd375493938;
  localparam logic [DEG_W-1:0]   PITCH_LIMIT = 18'd9000;
  localparam logic [DEG_W-1:0]   ROLL_LIMIT  = 18'd18000;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/atpr_cordic_stage.sv =====
// One registered CORDIC vectoring iteration with a side-band payload.
// Depends on atpr_pkg for the arctangent table.
module atpr_cordic_stage #(
  parameter int W   = 44,
  parameter int SW  = 8,
  parameter int IDX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 vld_in,
  input  logic signed [W-1:0]                  x_in,
  input  logic signed [W-1:0]                  y_in,
  input  logic signed [atpr_pkg::ANGLE_W-1:0]  a_in,
  input  logic [SW-1:0]                        side_in,
  output logic                                 vld,
  output logic signed [W-1:0]                  x,
  output logic signed [W-1:0]                  y,
  output logic signed [atpr_pkg::ANGLE_W-1:0]  a,
  output logic [SW-1:0]                        side
);
  import atpr_pkg::*;

  localparam logic signed [ANGLE_W-1:0] STEP = ANGLE_W'(atan_q30(IDX));

  logic signed [W-1:0]       dx, dy, x_next, y_next;
  logic signed [ANGLE_W-1:0] a_next;

  always_comb begin
    dx = y_in >>> IDX;
    dy = x_in >>> IDX;
    if (!y_in[W-1]) begin
      x_next = x_in + dx;
      y_next = y_in - dy;
      a_next = a_in + STEP;
    end else begin
      x_next = x_in - dx;
      y_next = y_in + dy;
      a_next = a_in - STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      a    <= a_next;
      side <= side_in;
    end
  end

endmodule

// ===== sv/accel_tilt_pitch_roll_top.sv =====
// Tilt angles from one accelerometer word: roll = atan2(y, z), pitch =
// atan2(x, |yz|), in centidegrees. One word per cycle while out_stall does
// not hold a waiting result. Stages: input register, ANGLE_STAGES roll CORDIC
// stages, ANGLE_STAGES pitch CORDIC stages, scale multiply, round/saturate.
// The pipeline holds as a whole while out_stall holds a waiting result.
// Synchronous reset clears valid bits only.
module accel_tilt_pitch_roll_top #(
  parameter int SAMPLE_BITS  = 16,
  parameter int ANGLE_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        accel_x,
  input  logic [SAMPLE_BITS-1:0]        accel_y,
  input  logic [SAMPLE_BITS-1:0]        accel_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [14:0]            pitch_centideg,
  output logic signed [15:0]            roll_centideg
);
  import atpr_pkg::*;

  localparam int W   = SAMPLE_BITS + GUARD_BITS + 4;
  localparam int PW  = SAMPLE_BITS + 32;
  localparam int SW1 = W + 2;
  localparam int SW2 = ANGLE_W + 2;
  localparam int N   = ANGLE_STAGES;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // input stage
  logic signed [W-1:0]       ys, zs, xr, yr, xp;
  logic signed [ANGLE_W-1:0] base;
  logic signed [PW-1:0]      prod;
  logic                      yz_zero, all_zero;

  always_comb begin
    ys = W'($signed(accel_y)) <<< GUARD_BITS;
    zs = W'($signed(accel_z)) <<< GUARD_BITS;
    yz_zero  = (accel_y == '0) && (accel_z == '0);
    all_zero = yz_zero && (accel_x == '0);
    prod = PW'($signed(accel_x)) * PW'($signed({1'b0, GAIN_Q30}));
    xp   = W'((prod + PW'(32)) >>> (30 - GUARD_BITS));
    xr   = zs;
    yr   = ys;
    base = '0;
    if (zs[W-1]) begin
      if (!ys[W-1]) begin
        xr   = ys;
        yr   = -zs;
        base = HALF_PI_Q30;
      end else begin
        xr   = -ys;
        yr   = zs;
        base = -HALF_PI_Q30;
      end
    end
  end

  logic                      rv   [0:N];
  logic signed [W-1:0]       rx   [0:N];
  logic signed [W-1:0]       ry   [0:N];
  logic signed [ANGLE_W-1:0] ra   [0:N];
  logic [SW1-1:0]            rs   [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (adv) begin
      rv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rx[0] <= xr;
      ry[0] <= yr;
      ra[0] <= base;
      rs[0] <= {xp, yz_zero, all_zero};
    end
  end

  // roll vectoring
  for (genvar i = 0; i < N; i++) begin : g_roll
    atpr_cordic_stage #(.W(W), .SW(SW1), .IDX(i)) u_stage (
      .clk(clk), .rst(rst), .en(adv),
      .vld_in(rv[i]), .x_in(rx[i]), .y_in(ry[i]), .a_in(ra[i]), .side_in(rs[i]),
      .vld(rv[i+1]), .x(rx[i+1]), .y(ry[i+1]), .a(ra[i+1]), .side(rs[i+1])
    );
  end

  // pitch vectoring: magnitude of (z, y) against gain-scaled x
  logic                      pv   [0:N];
  logic signed [W-1:0]       px   [0:N];
  logic signed [W-1:0]       py   [0:N];
  logic signed [ANGLE_W-1:0] pa   [0:N];
  logic [SW2-1:0]            ps   [0:N];

  assign pv[0] = rv[N];
  assign px[0] = rx[N];
  assign py[0] = rs[N][SW1-1:2];
  assign pa[0] = '0;
  assign ps[0] = {ra[N], rs[N][1:0]};

  for (genvar i = 0; i < N; i++) begin : g_pitch
    atpr_cordic_stage #(.W(W), .SW(SW2), .IDX(i)) u_stage (
      .clk(clk), .rst(rst), .en(adv),
      .vld_in(pv[i]), .x_in(px[i]), .y_in(py[i]), .a_in(pa[i]), .side_in(ps[i]),
      .vld(pv[i+1]), .x(px[i+1]), .y(py[i+1]), .a(pa[i+1]), .side(ps[i+1])
    );
  end

  // scale to centidegrees
  logic signed [ANGLE_W-1:0] roll_a, pitch_a;
  logic [ANGLE_W-1:0]        roll_mag, pitch_mag;
  logic                      mv, m_pneg, m_rneg, m_yz_zero, m_all_zero;
  logic [63:0]               m_pprod, m_rprod;

  always_comb begin
    pitch_a   = pa[N];
    roll_a    = ps[N][SW2-1:2];
    pitch_mag = pitch_a[ANGLE_W-1] ? ANGLE_W'(-pitch_a) : ANGLE_W'(pitch_a);
    roll_mag  = roll_a[ANGLE_W-1] ? ANGLE_W'(-roll_a) : ANGLE_W'(roll_a);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= pv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_pprod    <= 64'(pitch_mag) * 64'(CENTI_Q16);
      m_rprod    <= 64'(roll_mag) * 64'(CENTI_Q16);
      m_pneg     <= pitch_a[ANGLE_W-1];
      m_rneg     <= roll_a[ANGLE_W-1];
      m_yz_zero  <= ps[N][1];
      m_all_zero <= ps[N][0];
    end
  end

  // round, saturate, sign
  logic [63:0]      p_rnd, r_rnd;
  logic [DEG_W-1:0] p_deg, r_deg;
  logic [14:0]      p_out;
  logic [15:0]      r_out;

  always_comb begin
    p_rnd = m_pprod + (64'd1 << 45);
    r_rnd = m_rprod + (64'd1 << 45);
    p_deg = p_rnd[46 +: DEG_W];
    r_deg = r_rnd[46 +: DEG_W];
    if (p_deg > PITCH_LIMIT) p_deg = PITCH_LIMIT;
    if (r_deg > ROLL_LIMIT)  r_deg = ROLL_LIMIT;
    p_out = m_pneg ? 15'(-p_deg) : 15'(p_deg);
    r_out = m_rneg ? 16'(-r_deg) : 16'(r_deg);
    if (m_all_zero) p_out = '0;
    if (m_yz_zero)  r_out = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pitch_centideg <= $signed(p_out);
      roll_centideg  <= $signed(r_out);
    end
  end

endmodule

// ===== tb/sv/accel_tilt_pitch_roll_top_tb.sv =====
// Testbench for accel_tilt_pitch_roll_top: drives accelerometer words, predicts
// pitch and roll with a fixed-point CORDIC model, checks results in order.
// Depends on atpr_pkg and the top module only.
`timescale 1ns / 100ps

class tilt_scoreboard;
  typedef struct {
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  angles_t pending[$];
  int errors = 0;

  static function longint asr(longint v, int s);
    return v >>> s;
  endfunction

  static function longint vectorise(ref longint px, ref longint py);
    longint x, y, acc, dx, dy, t;
    x = px; y = py; acc = 0;
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i);
      dy = asr(x, i);
      t = longint'(atpr_pkg::atan_q30(i));
      if (y >= 0) begin
        x += dx; y -= dy; acc += t;
      end else begin
        x -= dx; y += dy; acc -= t;
      end
    end
    px = x; py = y;
    return acc;
  endfunction

  static function logic [63:0] centideg(longint theta, longint limit);
    logic [63:0] mag, r;
    mag = (theta < 0) ? -theta : theta;
    r = (mag * 64'd375493938 + (64'd1 << 45)) >> 46;
    if (r > limit) r = limit;
    if (theta < 0) r = -r;
    return r;
  endfunction

  function void note_word(logic signed [15:0] ax, logic signed [15:0] ay,
                          logic signed [15:0] az);
    longint xs, ys, zs, roll, pitch, mag, xr, yr, base, t, xp, m;
    angles_t a;
    logic [63:0] r;
    xs = ax; ys = ay; zs = az;
    roll = 0; pitch = 0; mag = 0;
    if (ys != 0 || zs != 0) begin
      xr = zs <<< 24; yr = ys <<< 24; base = 0;
      if (zs < 0) begin
        t = xr;
        if (ys >= 0) begin
          xr = yr; yr = -t; base = 1686629713;
        end else begin
          xr = -yr; yr = t; base = -1686629713;
        end
      end
      roll = base + vectorise(xr, yr);
      mag = xr;
    end
    if (xs != 0 || mag != 0) begin
      xp = asr(xs * 1768195363 + 32, 6);
      m = mag;
      pitch = vectorise(m, xp);
    end
    r = centideg(pitch, 9000); a.pitch = r[14:0];
    r = centideg(roll, 18000); a.roll = r[15:0];
    pending.push_back(a);
  endfunction

  function void check_result(logic signed [14:0] p, logic signed [15:0] r);
    angles_t e;
    if (pending.size() == 0) begin
      $error("unexpected result pitch=%0d roll=%0d", p, r);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (p !== e.pitch) begin
      $error("pitch_centideg expected %0d got %0d", e.pitch, p);
      errors++;
    end
    if (r !== e.roll) begin
      $error("roll_centideg expected %0d got %0d", e.roll, r);
      errors++;
    end
  endfunction
endclass

module accel_tilt_pitch_roll_top_tb;
  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0, in_stall, out_valid;
  logic [15:0] accel_x = 0, accel_y = 0, accel_z = 0;
  logic signed [14:0] pitch_centideg;
  logic signed [15:0] roll_centideg;
  int send_idle = 0, recv_idle = 0, hold_off = 0;
  bit hold_req = 0, hold_done = 0;
  longint cycles = 0;
  tilt_scoreboard sb = new();

  accel_tilt_pitch_roll_top uut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(pitch_centideg, roll_centideg);
    if (hold_req && !hold_done) begin
      hold_done <= 1;
      hold_off <= 200;
      out_stall <= 1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else
      out_stall <= ($urandom_range(99) < recv_idle);
  end

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    accel_x <= x; accel_y <= y; accel_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(x, y, z);
  endtask

  initial begin
    logic [15:0] edges[5];
    edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int i = 0; i < 25; i++)
      send_word(edges[$urandom_range(4)], edges[i % 5], edges[(i / 5) % 5]);
    send_word(16'd0, 16'd0, 16'd0);
    send_word(16'd100, 16'd0, 16'hFF00);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 7 : (ph == 1) ? 59 : 0;
      recv_idle = (ph == 0) ? 59 : (ph == 1) ? 7 : 0;
      if (ph == 2) hold_req = 1;
      for (int i = 0; i < 630; i++)
        send_word(pick_axis(), pick_axis(), pick_axis());
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== accel_tilt_pitch_roll_top.f =====
sv/atpr_pkg.sv
sv/atpr_cordic_stage.sv
sv/accel_tilt_pitch_roll_top.sv
tb/sv/accel_tilt_pitch_roll_top_tb.sv
